[design/dsr_pkg.sv]
`timescale 1ns / 1ps

package dsr_pkg;

    localparam int MAX_DATAGRAM = 4096;
    localparam int POS_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // input actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_FAIL     = 2'd2;

    // register indexes
    localparam logic REG_PAYLOAD_ID = 1'b0;
    localparam logic REG_MISS_LIMIT = 1'b1;

    // header byte offsets
    localparam int HDR_FLAGS      = 0;
    localparam int HDR_PAYLOAD_ID = 4;
    localparam int HDR_SECTION_HI = 8;
    localparam int HDR_SECTION_LO = 9;
    localparam int HDR_LAST_LO    = 10;
    localparam int HDR_EXTENSION  = 11;
    localparam int HDR_LEN        = 12;
    localparam int CRC_LEN        = 4;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       datagram_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       end_of_run;
    } out_item_t;

    // one queue entry: first result, plus a trailing completion when has_second
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       has_second;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[design/dsr_front.sv]
`timescale 1ns / 1ps

module dsr_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  dsr_pkg::in_item_t  in_data,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [7:0]         wr_data,
    output logic               push,
    output dsr_pkg::qentry_t   push_entry
);

    localparam logic [dsr_pkg::POS_W-1:0] POS_MAX = dsr_pkg::POS_W'(dsr_pkg::MAX_DATAGRAM);
    localparam logic [dsr_pkg::POS_W-1:0] POS_HDR = dsr_pkg::POS_W'(dsr_pkg::HDR_LEN);

    logic [7:0]                wanted_id_reg;
    logic [3:0]                miss_limit_reg;

    logic [dsr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [11:0]               exp_reg, exp_next;
    logic [11:0]               final_reg, final_next;
    logic [7:0]                sec_hi_reg, sec_hi_next;
    logic                      crc_reg, crc_next;
    logic                      prov_reg, prov_next;
    logic                      idok_reg, idok_next;
    logic                      secok_reg, secok_next;
    logic [3:0]                ext_reg, ext_next;
    logic [7:0]                delay_reg [dsr_pkg::CRC_LEN];
    logic [7:0]                delay_next [dsr_pkg::CRC_LEN];
    logic [2:0]                fill_reg, fill_next;
    logic                      zero_reg, zero_next;
    logic [3:0]                miss_reg, miss_next;

    logic [3:0]                miss_inc;
    logic [4:0]                start;
    logic [11:0]               sec;
    logic                      have;
    logic [7:0]                ob;
    logic                      pay_emit, complete, fail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_id_reg  <= 8'd1;
            miss_limit_reg <= 4'd4;
        end
        else if (wr_en)
        begin
            if (wr_index == dsr_pkg::REG_PAYLOAD_ID)
                wanted_id_reg <= wr_data;
            else
                miss_limit_reg <= wr_data[3:0];
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        exp_next   = exp_reg;
        final_next = final_reg;
        sec_hi_next = sec_hi_reg;
        crc_next   = crc_reg;
        prov_next  = prov_reg;
        idok_next  = idok_reg;
        secok_next = secok_reg;
        ext_next   = ext_reg;
        delay_next = delay_reg;
        fill_next  = fill_reg;
        zero_next  = zero_reg;
        miss_next  = miss_reg;
        pay_emit   = 1'b0;
        complete   = 1'b0;
        fail       = 1'b0;
        have       = 1'b0;
        ob         = 8'd0;
        miss_inc   = (miss_reg != 4'hF) ? miss_reg + 4'd1 : miss_reg;
        start      = 5'(dsr_pkg::HDR_LEN) + {prov_reg, 2'b00} + {1'b0, ext_reg};
        sec        = {sec_hi_reg, in_data.data_byte[7:4]};

        if (in_fire)
        begin
            if (in_data.action == dsr_pkg::ACT_TICK)
            begin
                if (miss_inc >= miss_limit_reg)
                begin
                    miss_next = 4'd0;
                    exp_next  = 12'd0;
                    fail      = 1'b1;
                end
                else
                begin
                    miss_next = miss_inc;
                end
            end
            else
            begin
                miss_next = 4'd0;
                if (pos_reg < POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_FLAGS))
                    begin
                        if (in_data.data_byte[1:0] != 2'b00)
                            crc_next = 1'b1;
                    end
                    else if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_PAYLOAD_ID))
                    begin
                        if (in_data.data_byte == wanted_id_reg)
                            idok_next = 1'b1;
                    end
                    else if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_SECTION_HI))
                    begin
                        sec_hi_next = in_data.data_byte;
                    end
                    else if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_SECTION_LO))
                    begin
                        if (sec == exp_reg)
                            secok_next = 1'b1;
                        final_next = {in_data.data_byte[3:0], 8'd0};
                    end
                    else if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_LAST_LO))
                    begin
                        final_next = {final_reg[11:8], in_data.data_byte};
                    end
                    else if (pos_reg == dsr_pkg::POS_W'(dsr_pkg::HDR_EXTENSION))
                    begin
                        prov_next = in_data.data_byte[4];
                        ext_next  = in_data.data_byte[3:0];
                    end
                    else if (pos_reg >= POS_HDR && idok_reg && secok_reg
                             && pos_reg >= dsr_pkg::POS_W'(start))
                    begin
                        if (crc_reg)
                        begin
                            // hold back the last four bytes as the trailing CRC
                            if (fill_reg >= 3'(dsr_pkg::CRC_LEN))
                            begin
                                ob            = delay_reg[0];
                                have          = 1'b1;
                                delay_next[0] = delay_reg[1];
                                delay_next[1] = delay_reg[2];
                                delay_next[2] = delay_reg[3];
                                delay_next[3] = in_data.data_byte;
                            end
                            else
                            begin
                                delay_next[fill_reg[1:0]] = in_data.data_byte;
                                fill_next = fill_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            ob   = in_data.data_byte;
                            have = 1'b1;
                        end
                        if (have && !zero_reg)
                        begin
                            if (ob == 8'd0)
                                zero_next = 1'b1;
                            else
                                pay_emit = 1'b1;
                        end
                    end
                end

                if (in_data.datagram_end)
                begin
                    if (pos_next >= POS_HDR && idok_next && secok_next)
                    begin
                        if (final_next > exp_reg)
                        begin
                            exp_next = exp_reg + 12'd1;
                        end
                        else
                        begin
                            exp_next = 12'd0;
                            complete = 1'b1;
                        end
                    end
                    pos_next    = '0;
                    sec_hi_next = 8'd0;
                    crc_next    = 1'b0;
                    prov_next   = 1'b0;
                    idok_next   = 1'b0;
                    secok_next  = 1'b0;
                    ext_next    = 4'd0;
                    for (int i = 0; i < dsr_pkg::CRC_LEN; i++)
                        delay_next[i] = 8'd0;
                    fill_next   = 3'd0;
                    zero_next   = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        push                    = pay_emit || complete || fail;
        push_entry.has_second   = 1'b0;
        push_entry.payload_byte = 8'd0;
        if (pay_emit)
        begin
            push_entry.kind         = dsr_pkg::KIND_PAYLOAD;
            push_entry.payload_byte = ob;
            push_entry.has_second   = complete;
        end
        else if (complete)
        begin
            push_entry.kind = dsr_pkg::KIND_COMPLETE;
        end
        else
        begin
            push_entry.kind = dsr_pkg::KIND_FAIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            exp_reg    <= 12'd0;
            final_reg  <= 12'd0;
            sec_hi_reg <= 8'd0;
            crc_reg    <= 1'b0;
            prov_reg   <= 1'b0;
            idok_reg   <= 1'b0;
            secok_reg  <= 1'b0;
            ext_reg    <= 4'd0;
            for (int i = 0; i < dsr_pkg::CRC_LEN; i++)
                delay_reg[i] <= 8'd0;
            fill_reg   <= 3'd0;
            zero_reg   <= 1'b0;
            miss_reg   <= 4'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            exp_reg    <= exp_next;
            final_reg  <= final_next;
            sec_hi_reg <= sec_hi_next;
            crc_reg    <= crc_next;
            prov_reg   <= prov_next;
            idok_reg   <= idok_next;
            secok_reg  <= secok_next;
            ext_reg    <= ext_next;
            delay_reg  <= delay_next;
            fill_reg   <= fill_next;
            zero_reg   <= zero_next;
            miss_reg   <= miss_next;
        end
    end

endmodule

[design/dsr_queue.sv]
`timescale 1ns / 1ps

module dsr_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dsr_pkg::qentry_t  push_entry,
    input  logic              pop,
    output dsr_pkg::qentry_t  head,
    output dsr_pkg::qstat_t   stat
);

    dsr_pkg::qentry_t            slot_reg [dsr_pkg::QUEUE_DEPTH];
    logic [dsr_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [dsr_pkg::QCNT_W-1:0]  count_reg;

    assign stat.full  = (count_reg == dsr_pkg::QCNT_W'(dsr_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!stat.full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dsr_pkg::QCNT_W'(dsr_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

[design/dsr_back.sv]
`timescale 1ns / 1ps

module dsr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  dsr_pkg::qentry_t   head,
    input  dsr_pkg::qstat_t    stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output dsr_pkg::out_item_t out_data
);

    logic               valid_reg;
    dsr_pkg::out_item_t out_reg;
    logic               pend_reg;
    logic               load;

    assign load      = !valid_reg || out_ready;
    assign pop       = load && !pend_reg && !stat.empty;
    assign out_valid = valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                out_reg.kind         <= dsr_pkg::KIND_COMPLETE;
                out_reg.payload_byte <= 8'd0;
                out_reg.end_of_run   <= 1'b1;
            end
            else
            begin
                out_reg.kind         <= head.kind;
                out_reg.payload_byte <= head.payload_byte;
                out_reg.end_of_run   <= !head.has_second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                // drain the trailing completion of the previous entry
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !stat.empty;
                pend_reg  <= !stat.empty && head.has_second;
            end
        end
    end

endmodule

[design/dvbstp_section_reassembler_unit.sv]
`timescale 1ns / 1ps
// Channel   Signals                         Handshake        Moves
// input     in_valid/in_ready/in_data       valid & ready    one datagram byte or tick
// output    out_valid/out_ready/out_data    valid & ready    one result word
// config    wr_en/wr_index/wr_data          wr_en            one register write
//
// One input word is taken per cycle while in_ready is high; each is parsed in
// the cycle it is taken. Results pass a four-entry queue to an output register
// and leave one per cycle while out_ready is high, so a word that causes two
// results leaves as two result words. in_ready drops only while the queue is full.
// Asynchronous active-low reset clears all parser state and the queue.

module dvbstp_section_reassembler_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dsr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dsr_pkg::out_item_t out_data,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [7:0]         wr_data
);

    logic             in_fire;
    logic             push;
    logic             pop;
    dsr_pkg::qentry_t push_entry;
    dsr_pkg::qentry_t head;
    dsr_pkg::qstat_t  stat;

    assign in_ready = !stat.full;
    assign in_fire  = in_valid && in_ready;

    dsr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_data    (in_data),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .push       (push),
        .push_entry (push_entry)
    );

    dsr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    dsr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
